// File: sv/equal_width_histogram_top_assert.svh
// assertion macros for the equal-width histogram block
`ifndef EQUAL_WIDTH_HISTOGRAM_TOP_ASSERT_SVH
`define EQUAL_WIDTH_HISTOGRAM_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EWH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EWH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ewh_pkg.sv
// shared types, codes and helpers for the equal-width histogram
package ewh_pkg;

  // field widths
  localparam int SAMPLE_W    = 32;
  localparam int WIDTH_W     = 31;
  localparam int CNT_W       = 32;
  localparam int KIND_W      = 2;
  localparam int BIN_INDEX_W = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int DIV_STEPS   = 32;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // input word kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MISSING = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READOUT = 2'd2;

  // result entry kinds
  localparam logic [KIND_W-1:0] EK_BIN     = 2'd0;
  localparam logic [KIND_W-1:0] EK_MISSING = 2'd1;
  localparam logic [KIND_W-1:0] EK_EMPTY   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LAST = 2'd2;

  // divider status towards the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // saturating increment of a counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

// File: sv/ewh_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module ewh_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ewh_pkg::SAMPLE_W-1:0] dividend,
  input  logic [ewh_pkg::WIDTH_W-1:0]  divisor,
  output ewh_pkg::div_stat_t          stat,
  output logic [ewh_pkg::SAMPLE_W-1:0] quotient
);
  import ewh_pkg::*;

  logic [SAMPLE_W-1:0] dq_r, dq_nxt;
  logic [WIDTH_W-1:0]  rem_r, rem_nxt;
  logic [WIDTH_W-1:0]  dvs_r;
  logic [STEP_W-1:0]   step_r;
  logic                busy_r;
  logic                done_r;
  logic [WIDTH_W:0]    trial;
  logic [WIDTH_W:0]    trial_sub;
  logic                ge;

  // one trial subtraction per cycle
  assign trial     = {rem_r, dq_r[SAMPLE_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});
  assign rem_nxt   = ge ? trial_sub[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
  assign dq_nxt    = {dq_r[SAMPLE_W-2:0], ge};

  // control: step counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as the quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

// File: sv/ewh_bins.sv
// bin counter memory with per-entry valid bits for instant clearing
module ewh_bins #(
  parameter int NUM_BINS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       rd_en,
  input  logic [$clog2(NUM_BINS)-1:0] rd_addr,
  output logic [ewh_pkg::CNT_W-1:0]  rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(NUM_BINS)-1:0] wr_addr,
  input  logic [ewh_pkg::CNT_W-1:0]  wr_data
);
  import ewh_pkg::*;

  logic [CNT_W-1:0]    mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;
  logic [CNT_W-1:0]    rd_q_r;
  logic                rd_vld_r;

  // valid bits: an entry not yet written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// File: sv/equal_width_histogram_top.sv
// top level of the equal-width histogram over Q16.16 samples
// Usage:
//   Input channel (in_valid / in_stall): each word carries in_kind and in_sample.
//   A sample word is binned by floor((sample - origin) / width); samples below the
//   origin are dropped, bins past the last one go to the overflow counter.
//   A missing word bumps the missing counter; a readout word streams the bin
//   counts from bin 0 to the highest bin used, then the missing count when
//   missing_last is set (with neither, one empty entry), and then clears all counters.
//   Output channel (out_valid / out_stall): the entries of a readout, out_last on the
//   final entry, with the pre-clear totals on every entry.
//   A sample word is accepted, passes the 32 steps of the bit-serial divider, then
//   a read and a write of the counter memory; in_stall holds off the next word
//   until the block is idle again. A missing word is counted as it is accepted.
//   A readout reads and then emits each bin entry in turn, then any tail entry,
//   and waits while the output is stalled; when no bin was used it goes straight
//   to the tail entry.
//   The output register is loaded only when empty or being taken, so a stall
//   simply holds the current entry and pauses the readout.
//   Reset (rst_n low, synchronous) restores origin 0, width 1.0, missing_last 0
//   and clears all counters at once; the block is ready on the next cycle.
module equal_width_histogram_top #(
  parameter int NUM_BINS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [ewh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ewh_pkg::SAMPLE_W-1:0]     cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ewh_pkg::KIND_W-1:0]       in_kind,
  input  logic signed [ewh_pkg::SAMPLE_W-1:0] in_sample,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ewh_pkg::KIND_W-1:0]       out_entry_kind,
  output logic [ewh_pkg::BIN_INDEX_W-1:0]  out_bin_index,
  output logic [ewh_pkg::CNT_W-1:0]        out_count,
  output logic [ewh_pkg::CNT_W-1:0]        out_missing_total,
  output logic [ewh_pkg::CNT_W-1:0]        out_overflow_total,
  output logic                             out_last
);
  import ewh_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);

  // controller states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV     = 3'd1;
  localparam logic [2:0] ST_UPD_WR  = 3'd2;
  localparam logic [2:0] ST_RO_RD   = 3'd3;
  localparam logic [2:0] ST_RO_EMIT = 3'd4;
  localparam logic [2:0] ST_RO_TAIL = 3'd5;

  // configuration registers
  logic signed [SAMPLE_W-1:0] origin_r;
  logic [WIDTH_W-1:0]         width_r;
  logic                       miss_last_r;

  // counters and control
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0] ovf_cnt_r, ovf_cnt_nxt;
  logic [IDX_W-1:0] highest_r, highest_nxt;
  logic             any_used_r, any_used_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_ek_r, out_ek_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [CNT_W-1:0] out_miss_r, out_miss_nxt;
  logic [CNT_W-1:0] out_ovf_r, out_ovf_nxt;
  logic             out_last_r, out_last_nxt;

  // datapath signals
  logic                  in_acc;
  logic                  out_free;
  logic signed [SAMPLE_W:0] diff;
  logic [WIDTH_W-1:0]    divisor;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [SAMPLE_W-1:0]   quot;
  logic                  bins_clr;
  logic                  bins_rd;
  logic [IDX_W-1:0]      bins_rd_addr;
  logic [CNT_W-1:0]      bins_rd_data;
  logic                  bins_wr;
  logic [IDX_W+BIN_INDEX_W-1:0] idx_ext;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // offset from the origin, negative means below it
  assign diff    = {in_sample[SAMPLE_W-1], in_sample} - {origin_r[SAMPLE_W-1], origin_r};
  assign divisor = (width_r == '0) ? WIDTH_W'(1) : width_r;

  ewh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff[SAMPLE_W-1:0]),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quot)
  );

  ewh_bins #(.NUM_BINS(NUM_BINS)) u_bins (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (bins_clr),
    .rd_en   (bins_rd),
    .rd_addr (bins_rd_addr),
    .rd_data (bins_rd_data),
    .wr_en   (bins_wr),
    .wr_addr (idx_r),
    .wr_data (sat_inc(bins_rd_data))
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r    <= '0;
      width_r     <= WIDTH_W'(65536);
      miss_last_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN:    origin_r    <= cfg_data;
        CFG_WIDTH:     width_r     <= cfg_data[WIDTH_W-1:0];
        CFG_MISS_LAST: miss_last_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // controller
  always_comb begin
    state_nxt     = state_r;
    miss_cnt_nxt  = miss_cnt_r;
    ovf_cnt_nxt   = ovf_cnt_r;
    highest_nxt   = highest_r;
    any_used_nxt  = any_used_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ek_nxt    = out_ek_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_miss_nxt  = out_miss_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    bins_clr      = 1'b0;
    bins_rd       = 1'b0;
    bins_rd_addr  = idx_r;
    bins_wr       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_SAMPLE: begin
              if (!diff[SAMPLE_W]) begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            KIND_MISSING: begin
              miss_cnt_nxt = sat_inc(miss_cnt_r);
            end
            KIND_READOUT: begin
              idx_nxt   = '0;
              state_nxt = any_used_r ? ST_RO_RD : ST_RO_TAIL;
            end
            default: ;
          endcase
        end
      end

      // wait for the quotient, then fetch the bin or count an overflow
      ST_DIV: begin
        if (div_stat.done) begin
          if (quot >= SAMPLE_W'(NUM_BINS)) begin
            ovf_cnt_nxt = sat_inc(ovf_cnt_r);
            state_nxt   = ST_IDLE;
          end else begin
            bins_rd      = 1'b1;
            bins_rd_addr = quot[IDX_W-1:0];
            idx_nxt      = quot[IDX_W-1:0];
            state_nxt    = ST_UPD_WR;
          end
        end
      end

      // write back the incremented count
      ST_UPD_WR: begin
        bins_wr = 1'b1;
        if (!any_used_r || idx_r > highest_r) begin
          highest_nxt = idx_r;
        end
        any_used_nxt = 1'b1;
        state_nxt    = ST_IDLE;
      end

      ST_RO_RD: begin
        bins_rd   = 1'b1;
        state_nxt = ST_RO_EMIT;
      end

      // one bin entry per pass
      ST_RO_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ek_nxt    = EK_BIN;
          out_idx_nxt   = idx_r;
          out_cnt_nxt   = bins_rd_data;
          out_miss_nxt  = miss_cnt_r;
          out_ovf_nxt   = ovf_cnt_r;
          out_last_nxt  = (idx_r == highest_r) && !miss_last_r;
          if (idx_r == highest_r) begin
            if (miss_last_r) begin
              state_nxt = ST_RO_TAIL;
            end else begin
              bins_clr     = 1'b1;
              miss_cnt_nxt = '0;
              ovf_cnt_nxt  = '0;
              highest_nxt  = '0;
              any_used_nxt = 1'b0;
              state_nxt    = ST_IDLE;
            end
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_RO_RD;
          end
        end
      end

      // missing entry or empty entry, then clear
      ST_RO_TAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ek_nxt    = miss_last_r ? EK_MISSING : EK_EMPTY;
          out_idx_nxt   = '0;
          out_cnt_nxt   = miss_last_r ? miss_cnt_r : '0;
          out_miss_nxt  = miss_cnt_r;
          out_ovf_nxt   = ovf_cnt_r;
          out_last_nxt  = 1'b1;
          bins_clr      = 1'b1;
          miss_cnt_nxt  = '0;
          ovf_cnt_nxt   = '0;
          highest_nxt   = '0;
          any_used_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      miss_cnt_r  <= '0;
      ovf_cnt_r   <= '0;
      highest_r   <= '0;
      any_used_r  <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      ovf_cnt_r   <= ovf_cnt_nxt;
      highest_r   <= highest_nxt;
      any_used_r  <= any_used_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_ek_r   <= out_ek_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_miss_r <= out_miss_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  // bin index narrowed to the port width
  assign idx_ext = {{BIN_INDEX_W{1'b0}}, out_idx_r};

  assign out_valid          = out_valid_r;
  assign out_entry_kind     = out_ek_r;
  assign out_bin_index      = idx_ext[BIN_INDEX_W-1:0];
  assign out_count          = out_cnt_r;
  assign out_missing_total  = out_miss_r;
  assign out_overflow_total = out_ovf_r;
  assign out_last           = out_last_r;

  // checks
  `include "equal_width_histogram_top_assert.svh"

  `EWH_ASSERT_NOW(a_div_active, state_r == ST_DIV,
                  div_stat.busy || div_stat.done, "divider idle while waited on")
  `EWH_ASSERT_NOW(a_done_in_div, div_stat.done, state_r == ST_DIV,
                  "quotient ready outside divide state")
  `EWH_ASSERT_NOW(a_highest_clear, !any_used_r, highest_r == '0,
                  "highest bin set with no bin used")
  `EWH_ASSERT_NEXT(a_readout_start, in_acc && in_kind == KIND_READOUT,
                   state_r == ST_RO_RD || state_r == ST_RO_TAIL, "readout did not start")

endmodule
